// File: sv/repeated_word_detector_macros.svh
// assertion macros for the repeated word detector
// expects clk and arst_n in the scope of each use
`ifndef REPEATED_WORD_DETECTOR_MACROS_SVH
`define REPEATED_WORD_DETECTOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define RWD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define RWD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/rwd_pkg.sv
// shared constants, types and helper functions of the repeated word detector
// no dependencies
package rwd_pkg;

	localparam int unsigned MAX_WORD   = 32;
	localparam int unsigned LINE_BITS  = 24;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned LINE_NUM_W = 24;
	localparam int unsigned LEN_W      = $clog2(MAX_WORD + 1);
	localparam int unsigned IDX_W      = $clog2(MAX_WORD);
	localparam int unsigned ADDR_W     = IDX_W + 1;
	localparam int unsigned MEM_DEPTH  = 2 ** ADDR_W;

	typedef logic [BYTE_W-1:0]     byte_t;
	typedef logic [LEN_W-1:0]      len_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [LINE_BITS-1:0]  line_t;
	typedef logic [LINE_NUM_W-1:0] line_num_t;

	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam byte_t CHAR_NL    = 8'h0A;
	localparam byte_t CHAR_TAB   = 8'h09;
	localparam byte_t CHAR_CR    = 8'h0D;
	localparam byte_t CHAR_SPACE = 8'h20;
	localparam byte_t CHAR_UC_A  = 8'h41;
	localparam byte_t CHAR_UC_Z  = 8'h5A;
	localparam byte_t CHAR_LC_A  = 8'h61;
	localparam byte_t CHAR_LC_Z  = 8'h7A;
	localparam byte_t CASE_BIT   = 8'h20;

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_CMP     = 2'd1;
	localparam logic [1:0] ST_EMIT_RD = 2'd2;
	localparam logic [1:0] ST_EMIT_WR = 2'd3;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		byte_t wdata;
		addr_t raddr;
	} mem_req_t;

	typedef struct packed {
		logic      valid;
		line_num_t line;
		byte_t     ch;
		logic      last;
	} push_t;

	function automatic logic is_space(byte_t c);
		return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
	endfunction

	function automatic logic is_upper(byte_t c);
		return c >= CHAR_UC_A && c <= CHAR_UC_Z;
	endfunction

	function automatic logic is_letter(byte_t c);
		return is_upper(c) || (c >= CHAR_LC_A && c <= CHAR_LC_Z);
	endfunction

	function automatic byte_t fold(byte_t c);
		return is_upper(c) ? (c | CASE_BIT) : c;
	endfunction

endpackage

// File: sv/rwd_in_if.sv
// input channel of the repeated word detector: text bytes and end of text
// depends on rwd_pkg
interface rwd_in_if;
	logic           valid;
	logic           ready;
	logic           kind;
	rwd_pkg::byte_t text_byte;

	modport source (output valid, output kind, output text_byte, input ready);
	modport sink (input valid, input kind, input text_byte, output ready);
endinterface

// File: sv/rwd_out_if.sv
// output channel of the repeated word detector: reported word bytes
// depends on rwd_pkg
interface rwd_out_if;
	logic               valid;
	logic               ready;
	rwd_pkg::line_num_t line_number;
	rwd_pkg::byte_t     word_char;
	logic               last_char;

	modport source (output valid, output line_number, output word_char, output last_char,
		input ready);
	modport sink (input valid, input line_number, input word_char, input last_char,
		output ready);
endinterface

// File: sv/repeated_word_detector.sv
// repeated word detector: a text byte that is compared with the stored byte of the previous
// word holds the input closed for a compare state (one registered read of the word memory)
// a report of an N-byte word holds the input closed, per byte a read, then a load of the
// output register, and longer while the report channel stalls
// asynchronous reset: line 1, empty previous word, no run; word memory is not cleared
// depends on rwd_pkg, rwd_in_if, rwd_out_if, rwd_word_mem, rwd_seq, rwd_out_stage
`include "repeated_word_detector_macros.svh"

module repeated_word_detector (
	input  logic      clk,
	input  logic      arst_n,
	rwd_in_if.sink    text_in,
	rwd_out_if.source report_out
);

	rwd_pkg::mem_req_t mem_req;
	rwd_pkg::push_t    push;
	rwd_pkg::byte_t    rd_data;
	logic              slot_free;

	rwd_word_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	rwd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_in   (text_in),
		.rd_data   (rd_data),
		.slot_free (slot_free),
		.mem_req   (mem_req),
		.push      (push)
	);

	rwd_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.slot_free  (slot_free),
		.report_out (report_out)
	);

	`RWD_ASSERT_IMP(a_push_blocks_input, push.valid, !text_in.ready, "report while input open")
	`RWD_ASSERT_IMP(a_push_into_free, push.valid, slot_free, "report byte into full slot")
	`RWD_ASSERT_NXT(a_last_frees_input, push.valid && push.last, text_in.ready,
		"input not reopened after last report byte")

endmodule

// File: sv/rwd_word_mem.sv
// word store: two banks of MAX_WORD bytes, current and previous word, swapped per word
// one write port, one registered read port; depends on rwd_pkg
module rwd_word_mem (
	input  logic              clk,
	input  rwd_pkg::mem_req_t req,
	output rwd_pkg::byte_t    rd_data
);

	rwd_pkg::byte_t mem [rwd_pkg::MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_data <= mem[req.raddr];
	end

endmodule

// File: sv/rwd_seq.sv
// sequencer: word tracking, byte compare against the previous word, report readout
// depends on rwd_pkg, rwd_in_if
module rwd_seq (
	input  logic              clk,
	input  logic              arst_n,
	rwd_in_if.sink            text_in,
	input  rwd_pkg::byte_t    rd_data,
	input  logic              slot_free,
	output rwd_pkg::mem_req_t mem_req,
	output rwd_pkg::push_t    push
);

	logic [1:0]          state_q;
	logic                inside_q;
	logic                mismatch_q;
	logic                first_letter_q;
	logic                run_rep_q;
	logic                sel_q;
	logic                emit_bank_q;
	rwd_pkg::len_t       cur_len_q;
	rwd_pkg::len_t       prev_len_q;
	rwd_pkg::len_t       emit_len_q;
	rwd_pkg::idx_t       emit_idx_q;
	rwd_pkg::line_t      line_q;
	rwd_pkg::line_num_t  rpt_line_q;
	rwd_pkg::byte_t      lc_q;

	logic                accept;
	logic                is_end;
	logic                is_sp;
	logic                room;
	logic                add_byte;
	logic                need_cmp;
	logic                equal;
	logic                start_emit;
	logic                emitting;
	logic                emit_last;
	rwd_pkg::byte_t      lc;
	rwd_pkg::len_t       len_eff;
	rwd_pkg::idx_t       wr_idx;

	assign text_in.ready = (state_q == rwd_pkg::ST_IDLE);
	assign accept        = text_in.valid && text_in.ready;
	assign is_end        = (text_in.kind == rwd_pkg::KIND_END);
	assign is_sp         = rwd_pkg::is_space(text_in.text_byte);
	assign lc            = rwd_pkg::fold(text_in.text_byte);
	assign len_eff       = inside_q ? cur_len_q : '0;
	assign wr_idx        = len_eff[rwd_pkg::IDX_W-1:0];
	assign room          = len_eff < rwd_pkg::LEN_W'(rwd_pkg::MAX_WORD);
	assign add_byte      = accept && !is_end && !is_sp && room;
	assign need_cmp      = add_byte && (len_eff < prev_len_q);
	assign equal         = !mismatch_q && (cur_len_q == prev_len_q) && (cur_len_q != '0)
		&& first_letter_q;
	assign start_emit    = equal && !run_rep_q;
	assign emitting      = (state_q == rwd_pkg::ST_EMIT_RD) || (state_q == rwd_pkg::ST_EMIT_WR);
	assign emit_last     = (rwd_pkg::LEN_W'(emit_idx_q) + rwd_pkg::LEN_W'(1)) == emit_len_q;

	assign mem_req.we    = add_byte;
	assign mem_req.waddr = {sel_q, wr_idx};
	assign mem_req.wdata = lc;
	assign mem_req.raddr = emitting ? {emit_bank_q, emit_idx_q} : {~sel_q, wr_idx};

	assign push.valid = (state_q == rwd_pkg::ST_EMIT_WR) && slot_free;
	assign push.line  = rpt_line_q;
	assign push.ch    = rd_data;
	assign push.last  = emit_last;

	always_ff @(posedge clk) begin
		if (add_byte) begin
			lc_q <= lc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= rwd_pkg::ST_IDLE;
			inside_q       <= 1'b0;
			mismatch_q     <= 1'b0;
			first_letter_q <= 1'b0;
			run_rep_q      <= 1'b0;
			sel_q          <= 1'b0;
			emit_bank_q    <= 1'b0;
			cur_len_q      <= '0;
			prev_len_q     <= '0;
			emit_len_q     <= '0;
			emit_idx_q     <= '0;
			line_q         <= rwd_pkg::LINE_BITS'(1);
			rpt_line_q     <= '0;
		end else begin
			unique case (state_q)
				rwd_pkg::ST_IDLE: begin
					if (accept && (is_end || is_sp)) begin
						// word end
						if (inside_q) begin
							if (start_emit) begin
								rpt_line_q  <= rwd_pkg::LINE_NUM_W'(line_q);
								emit_bank_q <= sel_q;
								emit_idx_q  <= '0;
								emit_len_q  <= cur_len_q;
								run_rep_q   <= 1'b1;
								state_q     <= rwd_pkg::ST_EMIT_RD;
							end else if (!equal) begin
								run_rep_q <= 1'b0;
							end
							prev_len_q <= cur_len_q;
							sel_q      <= ~sel_q;
							inside_q   <= 1'b0;
							cur_len_q  <= '0;
							mismatch_q <= 1'b0;
						end
						if (is_end) begin
							line_q     <= rwd_pkg::LINE_BITS'(1);
							prev_len_q <= '0;
							run_rep_q  <= 1'b0;
						end else if (text_in.text_byte == rwd_pkg::CHAR_NL && line_q != '1) begin
							line_q <= line_q + rwd_pkg::LINE_BITS'(1);
						end
					end else if (accept) begin
						inside_q <= 1'b1;
						if (!inside_q) begin
							mismatch_q <= 1'b0;
						end
						if (room) begin
							cur_len_q <= len_eff + rwd_pkg::LEN_W'(1);
							if (len_eff == '0) begin
								first_letter_q <= rwd_pkg::is_letter(text_in.text_byte);
							end
							if (!need_cmp) begin
								mismatch_q <= 1'b1;
							end
							if (need_cmp) begin
								state_q <= rwd_pkg::ST_CMP;
							end
						end
					end
				end
				rwd_pkg::ST_CMP: begin
					if (rd_data != lc_q) begin
						mismatch_q <= 1'b1;
					end
					state_q <= rwd_pkg::ST_IDLE;
				end
				rwd_pkg::ST_EMIT_RD: begin
					state_q <= rwd_pkg::ST_EMIT_WR;
				end
				rwd_pkg::ST_EMIT_WR: begin
					if (slot_free) begin
						emit_idx_q <= emit_idx_q + rwd_pkg::IDX_W'(1);
						state_q    <= emit_last ? rwd_pkg::ST_IDLE : rwd_pkg::ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= rwd_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/rwd_out_stage.sv
// output register between the sequencer and the report channel
// depends on rwd_pkg, rwd_out_if
module rwd_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  rwd_pkg::push_t push,
	output logic           slot_free,
	rwd_out_if.source      report_out
);

	logic               valid_q;
	rwd_pkg::line_num_t line_q;
	rwd_pkg::byte_t     ch_q;
	logic               last_q;

	assign slot_free              = !valid_q || report_out.ready;
	assign report_out.valid       = valid_q;
	assign report_out.line_number = line_q;
	assign report_out.word_char   = ch_q;
	assign report_out.last_char   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push.valid) begin
			valid_q <= 1'b1;
		end else if (report_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			line_q <= push.line;
			ch_q   <= push.ch;
			last_q <= push.last;
		end
	end

endmodule
